[hw/rtl/dlat_pkg.sv]
// ----------------------------------------------------------------------------
// dlat_pkg
// Types, constants and helpers shared by the dinucleotide look-ahead table.
// ----------------------------------------------------------------------------
package dlat_pkg;

  // alphabet and score formats
  localparam int ALPHABET_SIZE = 4;
  localparam int SYM_W         = 2;
  localparam int PROW_W        = 4;
  localparam int SCORE_W       = 16;
  localparam int SUM_W         = 24;

  localparam logic signed [SUM_W-1:0] Q24_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] Q24_MIN = -24'sh800000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_STEP,
    ST_TOTAL,
    ST_ERD,
    ST_ELD
  } state_t;

  // one look-ahead entry handed to the output register
  typedef struct packed {
    logic [3:0]               column;
    logic [SYM_W-1:0]         symbol;
    logic                     fin;
    logic signed [SUM_W-1:0]  max_total;
    logic signed [SUM_W-1:0]  min_total;
  } emit_t;

  // score plus running sum, saturated to the signed 24-bit range
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SUM_W-1:0]   b
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? Q24_MIN : Q24_MAX;
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/dlat_ram.sv]
// ----------------------------------------------------------------------------
// dlat_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dlat_core.sv]
// ----------------------------------------------------------------------------
// dlat_core
// Backward max-plus / min-plus recurrence over the score memory, writing the
// look-ahead table, then walking the table out one entry at a time.
// ----------------------------------------------------------------------------
module dlat_core #(
  parameter int MAX_COLS = 16,
  parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [CW-1:0]                         n_last,
  input  logic                                  slot_free,
  output logic                                  busy,
  output logic [CW+dlat_pkg::PROW_W-1:0]        sc_raddr,
  input  logic [dlat_pkg::SCORE_W-1:0]          sc_rdata,
  output logic                                  tb_we,
  output logic [CW+dlat_pkg::SYM_W-1:0]         tb_waddr,
  output logic [dlat_pkg::SUM_W-1:0]            tb_wdata,
  output logic [CW+dlat_pkg::SYM_W-1:0]         tb_raddr,
  output logic                                  emit_ld,
  output dlat_pkg::emit_t                       emit
);

  dlat_pkg::state_t state, state_next;

  logic [CW-1:0]                 col;
  logic [CW-1:0]                 nlast;
  logic [3:0]                    idx;
  logic                          first_col;
  logic                          b_valid;
  logic [3:0]                    b_idx;
  logic [dlat_pkg::SYM_W-1:0]    b_s;
  logic [dlat_pkg::SYM_W-1:0]    b_t;
  logic signed [dlat_pkg::SUM_W-1:0] acc_max;
  logic signed [dlat_pkg::SUM_W-1:0] acc_min;
  logic signed [dlat_pkg::SUM_W-1:0] cur_max [dlat_pkg::ALPHABET_SIZE];
  logic signed [dlat_pkg::SUM_W-1:0] cur_min [dlat_pkg::ALPHABET_SIZE];
  logic signed [dlat_pkg::SUM_W-1:0] nxt_max [dlat_pkg::ALPHABET_SIZE];
  logic signed [dlat_pkg::SUM_W-1:0] nxt_min [dlat_pkg::ALPHABET_SIZE];
  logic signed [dlat_pkg::SUM_W-1:0] max_total;
  logic signed [dlat_pkg::SUM_W-1:0] min_total;
  logic [CW-1:0]                 ocol;
  logic [dlat_pkg::SYM_W-1:0]    osym;
  logic                          fin;

  logic signed [dlat_pkg::SCORE_W-1:0] sc;
  logic signed [dlat_pkg::SUM_W-1:0]   sum_max, sum_min, best_max, best_min;
  logic signed [dlat_pkg::SUM_W-1:0]   tot_max, tot_min, m01, m23, n01, n23;

  assign b_s = b_idx[3:2];
  assign b_t = b_idx[1:0];
  assign sc  = $signed(sc_rdata);
  assign fin = (ocol == nlast) && (osym == 2'd3);

  // score read address: column being worked, pair row 4*s+t
  assign sc_raddr = {col, idx};
  assign tb_raddr = {ocol, osym};

  // recurrence step on the word returned by the score memory
  always_comb begin
    if (first_col) begin
      sum_max = dlat_pkg::SUM_W'(sc);
      sum_min = dlat_pkg::SUM_W'(sc);
    end else begin
      sum_max = dlat_pkg::sat_add(sc, nxt_max[b_t]);
      sum_min = dlat_pkg::sat_add(sc, nxt_min[b_t]);
    end
    best_max = ((b_t == 2'd0) || (sum_max > acc_max)) ? sum_max : acc_max;
    best_min = ((b_t == 2'd0) || (sum_min < acc_min)) ? sum_min : acc_min;
  end

  // table write when the fourth term of a symbol is in
  assign tb_we    = b_valid && (b_t == 2'd3);
  assign tb_waddr = {col, b_s};
  assign tb_wdata = best_max;

  // totals over the column-0 entries
  always_comb begin
    m01 = (nxt_max[1] > nxt_max[0]) ? nxt_max[1] : nxt_max[0];
    m23 = (nxt_max[3] > nxt_max[2]) ? nxt_max[3] : nxt_max[2];
    tot_max = (m23 > m01) ? m23 : m01;
    n01 = (nxt_min[1] < nxt_min[0]) ? nxt_min[1] : nxt_min[0];
    n23 = (nxt_min[3] < nxt_min[2]) ? nxt_min[3] : nxt_min[2];
    tot_min = (n23 < n01) ? n23 : n01;
  end

  // entry handed to the output register
  always_comb begin
    emit.column    = 4'(ocol);
    emit.symbol    = osym;
    emit.fin       = fin;
    emit.max_total = fin ? max_total : '0;
    emit.min_total = fin ? min_total : '0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    emit_ld    = 1'b0;
    busy       = 1'b1;
    unique case (state)
      dlat_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = dlat_pkg::ST_CALC;
      end
      dlat_pkg::ST_CALC: begin
        if (idx == 4'd15) state_next = dlat_pkg::ST_DRAIN;
      end
      dlat_pkg::ST_DRAIN: begin
        state_next = dlat_pkg::ST_STEP;
      end
      dlat_pkg::ST_STEP: begin
        state_next = (col == '0) ? dlat_pkg::ST_TOTAL : dlat_pkg::ST_CALC;
      end
      dlat_pkg::ST_TOTAL: begin
        state_next = dlat_pkg::ST_ERD;
      end
      dlat_pkg::ST_ERD: begin
        state_next = dlat_pkg::ST_ELD;
      end
      dlat_pkg::ST_ELD: begin
        if (slot_free) begin
          emit_ld    = 1'b1;
          state_next = fin ? dlat_pkg::ST_IDLE : dlat_pkg::ST_ERD;
        end
      end
      default: state_next = dlat_pkg::ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      idx       <= '0;
      col       <= '0;
      nlast     <= '0;
      first_col <= 1'b0;
      ocol      <= '0;
      osym      <= '0;
      max_total <= '0;
      min_total <= '0;
    end else begin
      b_valid <= (state == dlat_pkg::ST_CALC);
      if (state == dlat_pkg::ST_IDLE && start) begin
        col       <= n_last;
        nlast     <= n_last;
        idx       <= '0;
        first_col <= 1'b1;
      end
      if (state == dlat_pkg::ST_CALC) idx <= idx + 4'd1;
      if (state == dlat_pkg::ST_STEP) begin
        first_col <= 1'b0;
        if (col != '0) col <= col - CW'(1);
      end
      if (state == dlat_pkg::ST_TOTAL) begin
        max_total <= tot_max;
        min_total <= tot_min;
        ocol      <= '0;
        osym      <= '0;
      end
      if (emit_ld) begin
        osym <= osym + 2'd1;
        if (osym == 2'd3) ocol <= ocol + CW'(1);
      end
    end
  end

  // accumulators and column buffers
  always_ff @(posedge clk) begin
    b_idx <= idx;
    if (b_valid) begin
      acc_max <= best_max;
      acc_min <= best_min;
      if (b_t == 2'd3) begin
        cur_max[b_s] <= best_max;
        cur_min[b_s] <= best_min;
      end
    end
    if (state == dlat_pkg::ST_STEP) begin
      nxt_max <= cur_max;
      nxt_min <= cur_min;
    end
  end

  // checks
  a_tb_write_in_calc: assert property (@(posedge clk) disable iff (rst)
    tb_we |-> (state == dlat_pkg::ST_CALC || state == dlat_pkg::ST_DRAIN))
    else $error("table written outside the recurrence");

  a_calc_feeds_b: assert property (@(posedge clk) disable iff (rst)
    state == dlat_pkg::ST_CALC |=> b_valid)
    else $error("score read not followed by recurrence step");

  a_last_col_total: assert property (@(posedge clk) disable iff (rst)
    (state == dlat_pkg::ST_STEP && col == '0) |=> state == dlat_pkg::ST_TOTAL)
    else $error("column zero not followed by totals");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_ld |-> (state == dlat_pkg::ST_ELD && slot_free))
    else $error("entry emitted without a free output slot");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("start while busy");

endmodule

[hw/rtl/dinucleotide_lookahead_table_top.sv]
// ----------------------------------------------------------------------------
// dinucleotide_lookahead_table_top
// Dinucleotide weight matrix store with backward look-ahead table output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one Q8.8 score word per cycle,
//   addressed by column and pair_row; scores land in the score memory.
//   The word with last set is stored and then starts the recurrence; the
//   input stalls until the final table word is loaded into the output register.
//   Recurrence: per column in use, 16 score reads through the one read port
//   of the score memory, one drain and one column step; then the totals.
//   Output channel (out_valid / out_stall): 4 words per column, column 0
//   first, symbols 0..3; each word is a table memory read followed by an
//   output register load. overall_max / overall_min and last_out are set
//   on the final word only.
//   A stall on the output holds the output register; the sequencer waits.
//   cfg_we / cfg_wdata set cols_in_use (clamped to 1..min(MAX_COLS,16)).
//   Reset (rst, synchronous) sets cols_in_use to 16 and empties the output;
//   memory contents are not cleared.
// ----------------------------------------------------------------------------
module dinucleotide_lookahead_table_top #(
  parameter int MAX_COLS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] score,
  input  logic [3:0]         column,
  input  logic [3:0]         pair_row,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_column,
  output logic [1:0]         out_symbol,
  output logic signed [23:0] best_ahead,
  output logic signed [23:0] overall_max,
  output logic signed [23:0] overall_min,
  output logic               last_out
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LIM   = (MAX_COLS < 16) ? MAX_COLS : 16;
  localparam int SC_D  = MAX_COLS * 16;
  localparam int TB_D  = MAX_COLS * dlat_pkg::ALPHABET_SIZE;
  localparam int SAW   = CW + dlat_pkg::PROW_W;
  localparam int TAW   = CW + dlat_pkg::SYM_W;

  logic [4:0]        cols_in_use;
  logic [4:0]        n_cols;
  logic [CW-1:0]     n_last;
  logic              accept;
  logic              start;
  logic              busy;
  logic              sc_we;
  logic [SAW-1:0]    sc_waddr;
  logic [SAW-1:0]    sc_raddr;
  logic [15:0]       sc_rdata;
  logic              tb_we;
  logic [TAW-1:0]    tb_waddr;
  logic [23:0]       tb_wdata;
  logic [TAW-1:0]    tb_raddr;
  logic [23:0]       tb_rdata;
  logic              slot_free;
  logic              emit_ld;
  dlat_pkg::emit_t   emit;

  // column count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= 5'd16;
    end else if (cfg_we) begin
      cols_in_use <= cfg_wdata;
    end
  end

  // clamp into 1..LIM
  always_comb begin
    if (cols_in_use == 5'd0) begin
      n_cols = 5'd1;
    end else if (cols_in_use > 5'(LIM)) begin
      n_cols = 5'(LIM);
    end else begin
      n_cols = cols_in_use;
    end
  end
  assign n_last = CW'(n_cols - 5'd1);

  // input side
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && last;
  assign sc_we    = accept && (7'(column) < 7'(MAX_COLS));
  assign sc_waddr = {CW'(column), pair_row};

  dlat_ram #(
    .WIDTH (dlat_pkg::SCORE_W),
    .DEPTH (SC_D),
    .AW    (SAW)
  ) u_score_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (score),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  dlat_ram #(
    .WIDTH (dlat_pkg::SUM_W),
    .DEPTH (TB_D),
    .AW    (TAW)
  ) u_table_ram (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  dlat_core #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n_last    (n_last),
    .slot_free (slot_free),
    .busy      (busy),
    .sc_raddr  (sc_raddr),
    .sc_rdata  (sc_rdata),
    .tb_we     (tb_we),
    .tb_waddr  (tb_waddr),
    .tb_wdata  (tb_wdata),
    .tb_raddr  (tb_raddr),
    .emit_ld   (emit_ld),
    .emit      (emit)
  );

  // output register
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ld) begin
      out_column  <= emit.column;
      out_symbol  <= emit.symbol;
      best_ahead  <= $signed(tb_rdata);
      overall_max <= emit.max_total;
      overall_min <= emit.min_total;
      last_out    <= emit.fin;
    end
  end

endmodule

[test/dinucleotide_lookahead_table_top_test.sv]
// ----------------------------------------------------------------------------
// dinucleotide_lookahead_table_top_test
// Self-checking bench for the dinucleotide look-ahead table. Score words are
// loaded into the matrix and every word flagged last is run through a local
// max-plus / min-plus predictor. The emitted table words are compared field
// by field in order, with random idle gaps on the input and random stalls on
// the output.
// ----------------------------------------------------------------------------
module dinucleotide_lookahead_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALPHABET_SIZE = dlat_pkg::ALPHABET_SIZE;
  localparam int SYM_W         = dlat_pkg::SYM_W;
  localparam int PROW_W        = dlat_pkg::PROW_W;
  localparam int SCORE_W       = dlat_pkg::SCORE_W;
  localparam int SUM_W         = dlat_pkg::SUM_W;
  localparam logic signed [SUM_W-1:0] Q24_MAX = dlat_pkg::Q24_MAX;
  localparam logic signed [SUM_W-1:0] Q24_MIN = dlat_pkg::Q24_MIN;

  localparam int NUM_COLS      = 16;
  localparam int PAIR_ROWS     = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  localparam int IDLE_LIMIT    = 3000;

  // one expected word of the emitted table
  typedef struct {
    logic [3:0]              column;
    logic [SYM_W-1:0]        symbol;
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W-1:0] total_max;
    logic signed [SUM_W-1:0] total_min;
    logic                    fin;
  } table_word_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [4:0]                cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [SCORE_W-1:0] score = '0;
  logic [3:0]                column = '0;
  logic [PROW_W-1:0]         pair_row = '0;
  logic                      last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [3:0]                out_column;
  logic [SYM_W-1:0]          out_symbol;
  logic signed [SUM_W-1:0]   best_ahead;
  logic signed [SUM_W-1:0]   overall_max;
  logic signed [SUM_W-1:0]   overall_min;
  logic                      last_out;

  // predictor state
  logic signed [SCORE_W-1:0] score_mem [NUM_COLS][PAIR_ROWS];
  bit                        score_written [NUM_COLS][PAIR_ROWS];
  logic signed [SUM_W-1:0]   best_tab [NUM_COLS][ALPHABET_SIZE];
  logic signed [SUM_W-1:0]   worst_col [ALPHABET_SIZE];
  logic [4:0]                cols_setting = 5'd16;
  table_word_t               table_words_due [$];

  int  errors = 0;
  int  words_loaded = 0;
  int  random_words = 0;
  int  words_checked = 0;
  int  tables_built = 0;
  int  cfg_writes = 0;
  bit  fast_mode = 1'b0;

  dinucleotide_lookahead_table_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .score       (score),
    .column      (column),
    .pair_row    (pair_row),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_column  (out_column),
    .out_symbol  (out_symbol),
    .best_ahead  (best_ahead),
    .overall_max (overall_max),
    .overall_min (overall_min),
    .last_out    (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // score plus running sum, clamped to the 24-bit range
  function automatic logic signed [SUM_W-1:0] clamp_sum(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SUM_W-1:0]   b
  );
    int s;
    s = int'(a) + int'(b);
    if (s > int'(Q24_MAX)) return Q24_MAX;
    if (s < int'(Q24_MIN)) return Q24_MIN;
    return s[SUM_W-1:0];
  endfunction

  function automatic int cols_active(input logic [4:0] setting);
    int n;
    n = setting;
    if (n < 1) n = 1;
    if (n > NUM_COLS) n = NUM_COLS;
    return n;
  endfunction

  // backward recurrence over the columns in use, queues the table words
  function automatic void predict_lookahead_table();
    int                      n;
    logic signed [SUM_W-1:0] mx, mn, a, b, tmax, tmin;
    logic signed [SUM_W-1:0] nxt [ALPHABET_SIZE];
    table_word_t             w;
    n = cols_active(cols_setting);
    for (int s = 0; s < ALPHABET_SIZE; s++) begin
      mx = score_mem[n-1][4*s];
      mn = mx;
      for (int t = 1; t < ALPHABET_SIZE; t++) begin
        if (score_mem[n-1][4*s+t] > mx) mx = score_mem[n-1][4*s+t];
        if (score_mem[n-1][4*s+t] < mn) mn = score_mem[n-1][4*s+t];
      end
      best_tab[n-1][s] = mx;
      worst_col[s] = mn;
    end
    for (int c = n - 2; c >= 0; c--) begin
      nxt = worst_col;
      for (int s = 0; s < ALPHABET_SIZE; s++) begin
        for (int t = 0; t < ALPHABET_SIZE; t++) begin
          a = clamp_sum(score_mem[c][4*s+t], best_tab[c+1][t]);
          b = clamp_sum(score_mem[c][4*s+t], nxt[t]);
          if (t == 0 || a > mx) mx = a;
          if (t == 0 || b < mn) mn = b;
        end
        best_tab[c][s] = mx;
        worst_col[s] = mn;
      end
    end
    tmax = best_tab[0][0];
    tmin = worst_col[0];
    for (int s = 1; s < ALPHABET_SIZE; s++) begin
      if (best_tab[0][s] > tmax) tmax = best_tab[0][s];
      if (worst_col[s] < tmin) tmin = worst_col[s];
    end
    // totals only ride on the final word
    for (int c = 0; c < n; c++) begin
      for (int s = 0; s < ALPHABET_SIZE; s++) begin
        w.column    = 4'(c);
        w.symbol    = SYM_W'(s);
        w.best      = best_tab[c][s];
        w.fin       = (c == n - 1) && (s == ALPHABET_SIZE - 1);
        w.total_max = w.fin ? tmax : '0;
        w.total_min = w.fin ? tmin : '0;
        table_words_due.push_back(w);
      end
    end
    tables_built++;
  endfunction

  // send one score word and update the predictor once it is taken
  task automatic load_score(
    input logic signed [SCORE_W-1:0] val,
    input logic [3:0]                col,
    input logic [PROW_W-1:0]         prow,
    input logic                      fin
  );
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    score    <= val;
    column   <= col;
    pair_row <= prow;
    last     <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    score_mem[col][prow]     = val;
    score_written[col][prow] = 1'b1;
    words_loaded++;
    if (fin) predict_lookahead_table();
  endtask

  // hold the input and wait until every table word has come out
  task automatic drain_table();
    in_valid <= 1'b0;
    while (table_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cols_in_use(input logic [4:0] val);
    drain_table();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cols_setting = val;
    cfg_writes++;
  endtask

  // scores biased toward the extremes
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_cols();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(17, 31));
      3: return 5'($urandom_range(7, 15));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic compare_field(
    input string              name,
    input logic signed [31:0] expv,
    input logic signed [31:0] actv
  );
    if (actv !== expv) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  // output side: random stall per word, check each accepted word
  initial begin
    int          stall_left;
    table_word_t w;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (table_words_due.size() == 0) begin
          $display("%0t: unexpected word: column %0d symbol %0d best_ahead %0d",
                   $time, out_column, out_symbol, best_ahead);
          errors++;
        end else begin
          w = table_words_due.pop_front();
          compare_field("out_column", w.column, out_column);
          compare_field("out_symbol", w.symbol, out_symbol);
          compare_field("best_ahead", w.best, best_ahead);
          compare_field("overall_max", w.total_max, overall_max);
          compare_field("overall_min", w.total_min, overall_min);
          compare_field("last_out", w.fin, last_out);
          words_checked++;
        end
        stall_left = fast_mode ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // one column with the score extremes, last word on the final row
  task automatic test_single_column();
    logic signed [SCORE_W-1:0] pattern [PAIR_ROWS];
    pattern = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
                16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh7FFE,
                16'sh8001, 16'sh0100, 16'shFF00, 16'sh8000,
                16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh1234};
    set_cols_in_use(5'd1);
    for (int r = 0; r < PAIR_ROWS; r++) begin
      load_score(pattern[r], 4'd0, PROW_W'(r), r == PAIR_ROWS - 1);
    end
    drain_table();
  endtask

  // a zero column count behaves as one column
  task automatic test_zero_count_clamp();
    set_cols_in_use(5'd0);
    load_score(16'sh8000, 4'd0, 4'd3, 1'b1);
    drain_table();
  endtask

  // fill sequences with random content, noise and broken sequences
  task automatic test_random_sequences();
    int         phase, n, k, j;
    logic [7:0] missing [$];
    logic [7:0] tmp;
    phase = 0;
    while (random_words < 250 || phase < 10) begin
      fast_mode = ($urandom_range(0, 3) == 0);
      if (phase == 4) set_cols_in_use(5'd16);
      else if (phase == 7) set_cols_in_use(5'd31);
      else if (phase == 0 || $urandom_range(0, 2) != 0) set_cols_in_use(pick_cols());
      else if ($urandom_range(0, 1) == 1) drain_table();
      n = cols_active(cols_setting);
      // noise words anywhere in the matrix
      k = $urandom_range(0, 4);
      repeat (k) begin
        load_score(pick_score(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);
        random_words++;
      end
      // broken sequence: never flagged last
      if ($urandom_range(0, 5) == 0) begin
        phase++;
        continue;
      end
      missing.delete();
      for (int c = 0; c < n; c++) begin
        for (int r = 0; r < PAIR_ROWS; r++) begin
          if (!score_written[c][r]) missing.push_back({4'(c), 4'(r)});
        end
      end
      for (int i = missing.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = missing[i];
        missing[i] = missing[j];
        missing[j] = tmp;
      end
      if (missing.size() == 0) begin
        missing.push_back({4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
      end
      foreach (missing[i]) begin
        load_score(pick_score(), missing[i][7:4], missing[i][3:0], i == missing.size() - 1);
        random_words++;
      end
      phase++;
    end
    drain_table();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_column();
    test_zero_count_clamp();
    test_random_sequences();
    fast_mode = 1'b0;
    drain_table();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d score words (%0d random), %0d tables, %0d column count writes",
             words_loaded, random_words, tables_built, cfg_writes);
    $display("checked %0d table words with %0d errors", words_checked, errors);
    if (errors == 0 && table_words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (table_words_due.size() != 0) begin
        $display("%0t: %0d table words never came out", $time, table_words_due.size());
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dlat_pkg.sv
hw/rtl/dlat_ram.sv
hw/rtl/dlat_core.sv
hw/rtl/dinucleotide_lookahead_table_top.sv
test/dinucleotide_lookahead_table_top_test.sv
